// File: sv/pett_pkg.sv
// Package: shared types, codes and arithmetic helpers of the periodic event timer table.
package pett_pkg;

  localparam int Slots = 32;
  localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int MaxFire = 32;
  localparam int FireW = $clog2(MaxFire + 1);

  localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;
  localparam logic [31:0] PeriodMax = 32'h7FFF_FFFF;
  localparam logic [30:0] JitLimShort = 31'd10;
  localparam logic [30:0] JitLimMid = 31'd60;
  localparam logic [30:0] JitLimLong = 31'd300;
  localparam logic [4:0] JitSpanShort = 5'd6;
  localparam logic [4:0] JitSpanMid = 5'd12;
  localparam logic [4:0] JitSpanLong = 5'd20;

  localparam logic [2:0] ActAddPer = 3'd0;
  localparam logic [2:0] ActAddOne = 3'd1;
  localparam logic [2:0] ActDelete = 3'd2;
  localparam logic [2:0] ActUpdate = 3'd3;
  localparam logic [2:0] ActRun = 3'd4;
  localparam logic [2:0] ActQuery = 3'd5;

  localparam logic [2:0] KindAdded = 3'd0;
  localparam logic [2:0] KindFull = 3'd1;
  localparam logic [2:0] KindDeleted = 3'd2;
  localparam logic [2:0] KindNotFound = 3'd3;
  localparam logic [2:0] KindUpdated = 3'd4;
  localparam logic [2:0] KindFired = 3'd5;
  localparam logic [2:0] KindRunDone = 3'd6;
  localparam logic [2:0] KindNext = 3'd7;

  typedef struct packed {
    logic        enabled;
    logic        oneshot;
    logic [30:0] period;
    logic [31:0] deadline;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  slot;
    logic [15:0] fired_tag;
    logic [31:0] next_deadline;
    logic        none_pending;
    logic        last;
  } result_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? TimeMax : s[31:0];
  endfunction

  function automatic logic [30:0] jitter(input logic [30:0] d, input logic [15:0] r);
    logic [4:0]  span;
    logic [20:0] prod;
    logic [31:0] p;
    if (d <= JitLimShort) begin
      return d;
    end
    if (d <= JitLimMid) begin
      span = JitSpanShort;
    end else if (d <= JitLimLong) begin
      span = JitSpanMid;
    end else begin
      span = JitSpanLong;
    end
    prod = 21'(r) * 21'(span);
    p = 32'(d) + 32'(prod[20:16]) + 32'd1 - 32'(span >> 1);
    if (p > PeriodMax) begin
      p = PeriodMax;
    end
    return p[30:0];
  endfunction

endpackage

// File: sv/pett_if.sv
// Interfaces: operation and result channels of the timer table.
interface pett_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] tag;
  logic [31:0] now;
  logic [30:0] interval;
  logic [15:0] random;
  modport source (output valid, action, tag, now, interval, random, input ready);
  modport sink (input valid, action, tag, now, interval, random, output ready);
endinterface

interface pett_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [4:0]  slot;
  logic [15:0] fired_tag;
  logic [31:0] next_deadline;
  logic        none_pending;
  logic        last;
  modport source (output valid, kind, slot, fired_tag, next_deadline, none_pending, last,
                  input ready);
  modport sink (input valid, kind, slot, fired_tag, next_deadline, none_pending, last,
                output ready);
endinterface

// File: sv/pett_slot_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pett_slot_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                      rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/periodic_event_timer_table_core.sv
// Top level: timer slot table with sequential scan over a slot RAM.
//
//  channel | dir | transaction
//  in_ch   | in  | action, tag, now, interval, random
//  out_ch  | out | kind, slot, fired_tag, next_deadline, none_pending, last
//
// One operation at a time: PREP and START set up, then SCAN reads one slot per
// cycle from the single RAM read port unless a full result register stalls it,
// and FINISH closes run, query and failing searches. Add, delete and update end
// at the matching slot. Actions 6 and 7 are taken while idle and give no result.
// Reset clears state, output valid and active bits; slot fields come from add.
// A full result register stalls the scan; input is taken whenever idle.
module periodic_event_timer_table_core (
  input  logic      clk,
  input  logic      rst_n,
  pett_in_if.sink   in_ch,
  pett_out_if.source out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PREP   = 5'b00010,
    ST_START  = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  localparam logic [pett_pkg::SlotW-1:0] SlotLast = pett_pkg::SlotW'(pett_pkg::Slots - 1);

  state_t state_r, state_nxt;
  logic [pett_pkg::Slots-1:0] active_r, active_nxt;
  logic [pett_pkg::SlotW-1:0] idx_r, idx_nxt;
  logic [2:0]  act_r;
  logic [15:0] tag_r;
  logic [31:0] now_r;
  logic [30:0] ival_r;
  logic [15:0] rnd_r;
  logic [30:0] per_r;
  logic [31:0] dl_r;
  logic [31:0] min_r, min_nxt;
  logic        any_r, any_nxt;
  logic [pett_pkg::FireW-1:0] fire_r, fire_nxt;
  logic        out_valid_r;
  pett_pkg::result_t out_r;

  pett_pkg::entry_t cur, went;
  logic [$bits(pett_pkg::entry_t)-1:0] rdata;
  logic        we, re;
  logic [pett_pkg::SlotW-1:0] raddr;
  logic        out_free, load;
  pett_pkg::result_t res;
  logic        emit, wr, clr, set, found, stall, hit, slot_act;
  logic [31:0] idx_wide;

  pett_slot_ram #(
    .Width ($bits(pett_pkg::entry_t)),
    .Depth (pett_pkg::Slots)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (went),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cur = pett_pkg::entry_t'(rdata);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign idx_wide = 32'(idx_r);
  assign slot_act = active_r[idx_r];
  assign hit = slot_act && (cur.tag == tag_r);

  always_comb begin
    emit = 1'b0;
    wr = 1'b0;
    clr = 1'b0;
    set = 1'b0;
    found = 1'b0;
    went = cur;
    res = '0;
    min_nxt = min_r;
    any_nxt = any_r;
    fire_nxt = fire_r;
    unique case (act_r)
      pett_pkg::ActAddPer, pett_pkg::ActAddOne: begin
        if (!slot_act) begin
          wr = 1'b1;
          set = 1'b1;
          found = 1'b1;
          emit = 1'b1;
          went.enabled = (act_r == pett_pkg::ActAddOne) || (ival_r != '0);
          went.oneshot = (act_r == pett_pkg::ActAddOne);
          went.period = per_r;
          went.deadline = dl_r;
          went.tag = tag_r;
          res.kind = pett_pkg::KindAdded;
          res.slot = idx_wide[4:0];
          res.fired_tag = tag_r;
          res.last = 1'b1;
        end
      end
      pett_pkg::ActDelete: begin
        if (hit) begin
          clr = 1'b1;
          found = 1'b1;
          emit = 1'b1;
          res.kind = pett_pkg::KindDeleted;
          res.slot = idx_wide[4:0];
          res.fired_tag = tag_r;
          res.last = 1'b1;
        end
      end
      pett_pkg::ActUpdate: begin
        if (hit) begin
          wr = 1'b1;
          found = 1'b1;
          emit = 1'b1;
          went.oneshot = 1'b0;
          if (ival_r != '0) begin
            went.enabled = 1'b1;
            went.period = ival_r;
            if (dl_r < cur.deadline) begin
              went.deadline = dl_r;
            end
          end else begin
            went.enabled = 1'b0;
          end
          res.kind = pett_pkg::KindUpdated;
          res.slot = idx_wide[4:0];
          res.fired_tag = tag_r;
          res.last = 1'b1;
        end
      end
      pett_pkg::ActRun: begin
        if (slot_act && cur.enabled && (cur.deadline <= now_r) &&
            (32'(fire_r) < 32'(pett_pkg::MaxFire))) begin
          emit = 1'b1;
          fire_nxt = fire_r + 1'b1;
          res.kind = pett_pkg::KindFired;
          res.slot = idx_wide[4:0];
          res.fired_tag = cur.tag;
          if (cur.oneshot) begin
            clr = 1'b1;
          end else begin
            wr = 1'b1;
            went.deadline = pett_pkg::sat_add(now_r, 32'(cur.period));
          end
        end
      end
      pett_pkg::ActQuery: begin
        if (slot_act && cur.enabled && (!any_r || cur.deadline < min_r)) begin
          min_nxt = cur.deadline;
          any_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (state_r == ST_FINISH) begin
      res = '0;
      res.last = 1'b1;
      priority case (act_r)
        pett_pkg::ActAddPer, pett_pkg::ActAddOne: begin
          res.kind = pett_pkg::KindFull;
          res.fired_tag = tag_r;
        end
        pett_pkg::ActDelete, pett_pkg::ActUpdate: begin
          res.kind = pett_pkg::KindNotFound;
          res.fired_tag = tag_r;
        end
        pett_pkg::ActRun: begin
          res.kind = pett_pkg::KindRunDone;
        end
        default: begin
          res.kind = pett_pkg::KindNext;
          res.next_deadline = any_r ? min_r : '0;
          res.none_pending = !any_r;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    active_nxt = active_r;
    stall = emit && !out_free;
    we = 1'b0;
    re = 1'b0;
    raddr = idx_r + 1'b1;
    load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && (in_ch.action <= pett_pkg::ActQuery)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        re = 1'b1;
        raddr = '0;
        idx_nxt = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall) begin
          we = wr;
          load = emit;
          if (clr) begin
            active_nxt[idx_r] = 1'b0;
          end
          if (set) begin
            active_nxt[idx_r] = 1'b1;
          end
          if (found) begin
            state_nxt = ST_IDLE;
          end else if (idx_r == SlotLast) begin
            state_nxt = ST_FINISH;
          end else begin
            re = 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      active_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      active_r <= active_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (load) begin
      out_r <= res;
    end
    if (state_r == ST_IDLE && in_ch.valid) begin
      act_r <= in_ch.action;
      tag_r <= in_ch.tag;
      now_r <= in_ch.now;
      ival_r <= in_ch.interval;
      rnd_r <= in_ch.random;
    end
    if (state_r == ST_PREP) begin
      per_r <= (act_r == pett_pkg::ActAddPer) ? pett_pkg::jitter(ival_r, rnd_r) : '0;
    end
    if (state_r == ST_START) begin
      min_r <= '0;
      any_r <= 1'b0;
      fire_r <= '0;
      if (act_r == pett_pkg::ActAddPer) begin
        dl_r <= (ival_r == '0) ? '0 : pett_pkg::sat_add(now_r, 32'(per_r));
      end else begin
        dl_r <= pett_pkg::sat_add(now_r, 32'(ival_r));
      end
    end else if (state_r == ST_SCAN && !stall) begin
      min_r <= min_nxt;
      any_r <= any_nxt;
      fire_r <= fire_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind = out_r.kind;
  assign out_ch.slot = out_r.slot;
  assign out_ch.fired_tag = out_r.fired_tag;
  assign out_ch.next_deadline = out_r.next_deadline;
  assign out_ch.none_pending = out_r.none_pending;
  assign out_ch.last = out_r.last;

endmodule

// File: tb/sv/periodic_event_timer_table_core_test.sv
// Testbench: randomized and directed check of the timer table core against a local slot model.
`timescale 1ns / 1ps

module periodic_event_timer_table_core_test;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] tag;
    logic [31:0] now;
    logic [30:0] interval;
    logic [15:0] rnd;
  } timer_op_t;

  localparam int CycleLimit = 400000;
  localparam logic [2:0] ActBad6 = 3'd6;
  localparam logic [2:0] ActBad7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pett_in_if in_ch ();
  pett_out_if out_ch ();

  periodic_event_timer_table_core uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic        tbl_active [pett_pkg::Slots];
  logic        tbl_enabled [pett_pkg::Slots];
  logic        tbl_oneshot [pett_pkg::Slots];
  logic [30:0] tbl_period [pett_pkg::Slots];
  logic [31:0] tbl_deadline [pett_pkg::Slots];
  logic [15:0] tbl_tag [pett_pkg::Slots];

  timer_op_t pending_ops[$];
  pett_pkg::result_t expected_results[$];
  int errors = 0;
  int ops_taken = 0;
  int results_seen = 0;
  int fired_seen = 0;
  int full_seen = 0;
  int cycles = 0;
  bit steady_send = 1'b0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;

  function automatic logic [31:0] time_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [30:0] jittered_period(logic [30:0] d, logic [15:0] r);
    longint delta;
    longint p;
    if (d <= 31'd10) return d;
    delta = (d <= 31'd60) ? 3 : ((d <= 31'd300) ? 6 : 10);
    p = longint'(d) + ((2 * delta * longint'(r)) >>> 16) + 1 - delta;
    if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
    return p[30:0];
  endfunction

  function automatic pett_pkg::result_t mk_result(logic [2:0] kind, int slot, logic [15:0] tag,
                                                  logic [31:0] nxt, logic none, logic last);
    pett_pkg::result_t r;
    r.kind = kind;
    r.slot = slot[4:0];
    r.fired_tag = tag;
    r.next_deadline = nxt;
    r.none_pending = none;
    r.last = last;
    return r;
  endfunction

  task automatic predict_table_op(timer_op_t op);
    int idx;
    int fired;
    logic any;
    logic [31:0] m;
    logic [31:0] t;
    idx = -1;
    case (op.action)
      pett_pkg::ActAddPer, pett_pkg::ActAddOne: begin
        for (int i = 0; i < pett_pkg::Slots; i++) if (idx < 0 && !tbl_active[i]) idx = i;
        if (idx < 0) begin
          expected_results.push_back(mk_result(pett_pkg::KindFull, 0, op.tag, 32'd0,
                                               1'b0, 1'b1));
        end else begin
          tbl_active[idx] = 1'b1;
          tbl_tag[idx] = op.tag;
          if (op.action == pett_pkg::ActAddOne) begin
            tbl_enabled[idx] = 1'b1;
            tbl_oneshot[idx] = 1'b1;
            tbl_period[idx] = '0;
            tbl_deadline[idx] = time_sum(op.now, {1'b0, op.interval});
          end else if (op.interval == 0) begin
            tbl_enabled[idx] = 1'b0;
            tbl_oneshot[idx] = 1'b0;
            tbl_period[idx] = '0;
            tbl_deadline[idx] = '0;
          end else begin
            tbl_enabled[idx] = 1'b1;
            tbl_oneshot[idx] = 1'b0;
            tbl_period[idx] = jittered_period(op.interval, op.rnd);
            tbl_deadline[idx] = time_sum(op.now, {1'b0, tbl_period[idx]});
          end
          expected_results.push_back(mk_result(pett_pkg::KindAdded, idx, op.tag, 32'd0,
                                               1'b0, 1'b1));
        end
      end
      pett_pkg::ActDelete, pett_pkg::ActUpdate: begin
        for (int i = 0; i < pett_pkg::Slots; i++)
          if (idx < 0 && tbl_active[i] && tbl_tag[i] == op.tag) idx = i;
        if (idx < 0) begin
          expected_results.push_back(mk_result(pett_pkg::KindNotFound, 0, op.tag, 32'd0,
                                               1'b0, 1'b1));
        end else if (op.action == pett_pkg::ActDelete) begin
          tbl_active[idx] = 1'b0;
          expected_results.push_back(mk_result(pett_pkg::KindDeleted, idx, op.tag, 32'd0,
                                               1'b0, 1'b1));
        end else begin
          tbl_oneshot[idx] = 1'b0;
          if (op.interval != 0) begin
            t = time_sum(op.now, {1'b0, op.interval});
            tbl_enabled[idx] = 1'b1;
            tbl_period[idx] = op.interval;
            if (t < tbl_deadline[idx]) tbl_deadline[idx] = t;
          end else begin
            tbl_enabled[idx] = 1'b0;
          end
          expected_results.push_back(mk_result(pett_pkg::KindUpdated, idx, op.tag, 32'd0,
                                               1'b0, 1'b1));
        end
      end
      pett_pkg::ActRun: begin
        fired = 0;
        for (int i = 0; i < pett_pkg::Slots; i++) begin
          if (fired < pett_pkg::MaxFire && tbl_active[i] && tbl_enabled[i] &&
              tbl_deadline[i] <= op.now) begin
            expected_results.push_back(mk_result(pett_pkg::KindFired, i, tbl_tag[i], 32'd0,
                                                 1'b0, 1'b0));
            fired++;
            if (tbl_oneshot[i]) tbl_active[i] = 1'b0;
            else tbl_deadline[i] = time_sum(op.now, {1'b0, tbl_period[i]});
          end
        end
        expected_results.push_back(mk_result(pett_pkg::KindRunDone, 0, 16'h0000, 32'd0,
                                             1'b0, 1'b1));
      end
      pett_pkg::ActQuery: begin
        any = 1'b0;
        m = '0;
        for (int i = 0; i < pett_pkg::Slots; i++) begin
          if (tbl_active[i] && tbl_enabled[i] && (!any || tbl_deadline[i] < m)) begin
            m = tbl_deadline[i];
            any = 1'b1;
          end
        end
        expected_results.push_back(mk_result(pett_pkg::KindNext, 0, 16'h0000,
                                             any ? m : 32'd0, !any, 1'b1));
      end
      default: ;
    endcase
  endtask

  function automatic timer_op_t mk_op(logic [2:0] a, logic [15:0] tag, logic [31:0] now,
                                      logic [30:0] ival, logic [15:0] rnd);
    timer_op_t op;
    op.action = a;
    op.tag = tag;
    op.now = now;
    op.interval = ival;
    op.rnd = rnd;
    return op;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin
    timer_op_t op;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_table_op({in_ch.action, in_ch.tag, in_ch.now, in_ch.interval, in_ch.random});
        ops_taken <= ops_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() > 0 && (steady_send || $urandom_range(99) >= 22)) begin
          op = pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= op.action;
          in_ch.tag <= op.tag;
          in_ch.now <= op.now;
          in_ch.interval <= op.interval;
          in_ch.random <= op.rnd;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && ops_taken >= 70) begin
      hold_cnt <= 400;
      hold_done <= 1'b1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    pett_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (out_ch.kind == pett_pkg::KindFired) fired_seen <= fired_seen + 1;
        if (out_ch.kind == pett_pkg::KindFull) full_seen <= full_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction, kind %0d", out_ch.kind);
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
            errors = errors + 1;
          end
          if (out_ch.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_ch.slot);
            errors = errors + 1;
          end
          if (out_ch.fired_tag !== want.fired_tag) begin
            $error("fired_tag: expected %0h, got %0h", want.fired_tag, out_ch.fired_tag);
            errors = errors + 1;
          end
          if (out_ch.next_deadline !== want.next_deadline) begin
            $error("next_deadline: expected %0h, got %0h", want.next_deadline,
                   out_ch.next_deadline);
            errors = errors + 1;
          end
          if (out_ch.none_pending !== want.none_pending) begin
            $error("none_pending: expected %0d, got %0d", want.none_pending,
                   out_ch.none_pending);
            errors = errors + 1;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            errors = errors + 1;
          end
        end
      end
      out_ch.ready <= (hold_cnt > 0) ? 1'b0 : (steady_send || $urandom_range(99) >= 22);
    end
  end

  initial begin
    logic [31:0] clock_now;
    logic [2:0] act;
    logic [30:0] ival;
    logic [15:0] tag;
    int sel;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.tag = '0;
    in_ch.now = '0;
    in_ch.interval = '0;
    in_ch.random = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < pett_pkg::Slots; i++) begin
      tbl_active[i] = 1'b0;
      tbl_enabled[i] = 1'b0;
      tbl_oneshot[i] = 1'b0;
      tbl_period[i] = '0;
      tbl_deadline[i] = '0;
      tbl_tag[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    pending_ops.push_back(mk_op(pett_pkg::ActQuery, 16'h0000, 32'd0, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActRun, 16'hFFFF, 32'd0, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActAddPer, 16'h0001, 32'd100, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActAddPer, 16'h0002, 32'd100, 31'd10, 16'hFFFF));
    pending_ops.push_back(mk_op(pett_pkg::ActAddPer, 16'h0003, 32'd100, 31'd11, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActAddPer, 16'h0004, 32'd100, 31'd60, 16'hFFFF));
    pending_ops.push_back(mk_op(pett_pkg::ActAddPer, 16'h0005, 32'd100, 31'd61, 16'h8000));
    pending_ops.push_back(mk_op(pett_pkg::ActAddPer, 16'h0006, 32'd100, 31'd300, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActAddPer, 16'h0007, 32'd100, 31'd301, 16'hFFFF));
    pending_ops.push_back(mk_op(pett_pkg::ActAddPer, 16'hFFFF, 32'hFFFF_FFF0, 31'h7FFF_FFFF,
                                16'hFFFF));
    pending_ops.push_back(mk_op(pett_pkg::ActAddOne, 16'h0002, 32'd100, 31'd5, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActAddOne, 16'hAAAA, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                                16'h5555));
    pending_ops.push_back(mk_op(pett_pkg::ActQuery, 16'h0000, 32'd100, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActUpdate, 16'h0002, 32'd100, 31'd3, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActUpdate, 16'h0006, 32'd100, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActUpdate, 16'h0001, 32'd100, 31'd2, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActQuery, 16'h0000, 32'd100, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActRun, 16'h0000, 32'd110, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActDelete, 16'h0002, 32'd110, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActDelete, 16'h1234, 32'd110, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActUpdate, 16'h4321, 32'd110, 31'd9, 16'h0000));
    pending_ops.push_back(mk_op(ActBad6, 16'h0001, 32'd110, 31'd1, 16'h0001));
    pending_ops.push_back(mk_op(ActBad7, 16'h0001, 32'd110, 31'd1, 16'h0001));
    pending_ops.push_back(mk_op(pett_pkg::ActRun, 16'h0000, 32'hFFFF_FFFF, 31'd0, 16'h0000));
    pending_ops.push_back(mk_op(pett_pkg::ActQuery, 16'h0000, 32'hFFFF_FFFF, 31'd0,
                                16'h0000));

    // wait until the directed part has fully drained before queueing random operations
    wait (pending_ops.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (pett_pkg::Slots + 8) @(posedge clk);

    clock_now = 32'd1000;
    for (int n = 0; n < 180; n++) begin
      if (n == 110) begin
        wait (pending_ops.size() == 0);
        steady_send = 1'b1;
      end
      if (n == 150) begin
        wait (pending_ops.size() == 0);
        steady_send = 1'b0;
      end
      clock_now = clock_now + 32'($urandom_range(0, 15));
      sel = $urandom_range(99);
      if (sel < 30) act = pett_pkg::ActAddPer;
      else if (sel < 45) act = pett_pkg::ActAddOne;
      else if (sel < 55) act = pett_pkg::ActDelete;
      else if (sel < 65) act = pett_pkg::ActUpdate;
      else if (sel < 85) act = pett_pkg::ActRun;
      else if (sel < 97) act = pett_pkg::ActQuery;
      else act = $urandom_range(1) ? ActBad6 : ActBad7;
      sel = $urandom_range(99);
      if (sel < 15) ival = 31'd0;
      else if (sel < 70) ival = 31'($urandom_range(1, 40));
      else if (sel < 90) ival = 31'($urandom_range(41, 400));
      else ival = 31'($urandom);
      tag = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
      pending_ops.push_back(mk_op(act, tag,
                                  ($urandom_range(19) == 0) ? 32'($urandom) : clock_now,
                                  ival, 16'($urandom)));
    end

    wait (pending_ops.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (pett_pkg::Slots + 10) @(posedge clk);
    $display("covered %0d operations, %0d results, %0d firings, %0d table-full replies",
             ops_taken, results_seen, fired_seen, full_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
